// ===== rtl/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, constants and the single-bit division step for the
// fragment check value block.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // Header layout
  localparam logic [3:0] HEADER_BYTES = 4'd9;
  localparam logic [3:0] CHECK_POS_HI = 4'd4;
  localparam logic [3:0] CHECK_POS_LO = 4'd5;
  localparam logic [3:0] FLAG_POS     = 4'd8;

  // Tail split over two stages: high part then low part
  localparam int TAIL_HI_BITS = 8;
  localparam int TAIL_LO_BITS = 7;

  localparam logic [15:0] GENERATOR_RESET = 16'hD175;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR  = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } fcc_in_t;

  typedef struct packed {
    logic [14:0] remainder;
    logic        fragment_ok;
    logic [31:0] sequence_number;
    logic [7:0]  frame_flag;
    logic        too_short;
  } fcc_out_t;

  // Work handed from the byte stage to the tail pipeline
  typedef struct packed {
    logic [15:0] div;
    logic [14:0] tail;
    logic        short_frag;
    logic [31:0] seq;
    logic [7:0]  flag;
  } fcc_tail_job_t;

  // One step of the long division, MSB first
  function automatic logic [15:0] div_bit(input logic [15:0] div,
                                          input logic [15:0] gen,
                                          input logic        b);
    logic [15:0] shifted;
    shifted = {div[14:0], b};
    return shifted[15] ? (shifted ^ gen) : shifted;
  endfunction

endpackage

// ===== rtl/fcc_tail_pipe.sv =====
// ----------------------------------------------------------------------------
// fcc_tail_pipe
// Shifts the 15 tail bits into the division register over two stages and
// holds the finished result in the output register.
// ----------------------------------------------------------------------------
module fcc_tail_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            generator,
  input  logic                   job_valid,
  input  fcc_pkg::fcc_tail_job_t job,
  output logic                   job_free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output fcc_pkg::fcc_out_t      out_data
);

  logic                   t1_v_r, t1_v_nxt;
  fcc_pkg::fcc_tail_job_t t1_r;
  logic                   t2_v_r, t2_v_nxt;
  fcc_pkg::fcc_tail_job_t t2_r, t2_nxt;
  logic                   o_v_r, o_v_nxt;
  fcc_pkg::fcc_out_t      o_r, o_nxt;
  logic                   out_free, t2_free, t1_free;

  // Ready chain, bubbles collapse
  assign out_free = !o_v_r || !out_stall;
  assign t2_free  = !t2_v_r || out_free;
  assign t1_free  = !t1_v_r || t2_free;
  assign job_free = t1_free;

  assign t1_v_nxt = t1_free ? job_valid : t1_v_r;
  assign t2_v_nxt = t2_free ? t1_v_r : t2_v_r;
  assign o_v_nxt  = out_free ? t2_v_r : o_v_r;

  // First tail stage: bits 14..7
  always_comb begin
    logic [15:0] d;
    d = t1_r.div;
    for (int i = 0; i < fcc_pkg::TAIL_HI_BITS; i++) begin
      d = fcc_pkg::div_bit(d, generator, t1_r.tail[14-i]);
    end
    t2_nxt     = t1_r;
    t2_nxt.div = d;
  end

  // Second tail stage: bits 6..0, then format the result
  always_comb begin
    logic [15:0] d;
    d = t2_r.div;
    for (int i = 0; i < fcc_pkg::TAIL_LO_BITS; i++) begin
      d = fcc_pkg::div_bit(d, generator, t2_r.tail[6-i]);
    end
    if (t2_r.short_frag) begin
      o_nxt           = '0;
      o_nxt.too_short = 1'b1;
    end else begin
      o_nxt.remainder       = d[14:0];
      o_nxt.fragment_ok     = (d == 16'd0);
      o_nxt.sequence_number = t2_r.seq;
      o_nxt.frame_flag      = t2_r.flag;
      o_nxt.too_short       = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      t1_v_r <= t1_v_nxt;
      t2_v_r <= t2_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (t1_free) t1_r <= job;
    if (t2_free) t2_r <= t2_nxt;
    if (out_free) o_r <= o_nxt;
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

// ===== rtl/fragment_crc15_checker.sv =====
// ----------------------------------------------------------------------------
// fragment_crc15_checker
// Checks or generates the 15-bit check value of a datagram fragment.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle, back to back and across fragment
// boundaries, but a byte marked last waits in the input register until
// the tail pipeline has room; the rate is set by the byte stage, which
// runs all eight division steps of a byte combinationally. The fragment
// header is 9 bytes: sequence number (bytes 0-3, big-endian), check field
// (bytes 4-5, divided as zero), length and the flag byte (byte 8). After
// the byte marked last the 15 tail bits (received check bits 14..0 in
// check mode, zeros in generate mode) pass through two tail stages, and
// the result is held in the output register, which drives out_valid.
// Configuration: index 0 is check_mode, index 1 the 16-bit generator; write
// only while the block is idle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module fragment_crc15_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fcc_pkg::fcc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcc_pkg::fcc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);

  // Configuration registers
  logic        check_mode_r;
  logic [15:0] generator_r;

  // Input register
  logic             in_v_r, in_v_nxt;
  fcc_pkg::fcc_in_t in_r;

  // Fragment state
  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] div_r, div_nxt;
  logic [15:0] rcv_r, rcv_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [7:0]  flag_r, flag_nxt;

  fcc_pkg::fcc_tail_job_t job;
  logic                   job_valid, job_free;
  logic                   take, s0_free;

  assign cfg_ready = 1'b1;

  // Configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b0;
      generator_r  <= fcc_pkg::GENERATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fcc_pkg::CFG_CHECK_MODE) check_mode_r <= cfg_data[0];
      else if (cfg_index == fcc_pkg::CFG_GENERATOR) generator_r <= cfg_data;
    end
  end

  // Handshake: a last byte waits for room in the tail pipeline
  assign take      = !in_r.last || job_free;
  assign s0_free   = !in_v_r || take;
  assign in_stall  = !s0_free;
  assign in_v_nxt  = s0_free ? in_valid : in_v_r;
  assign job_valid = in_v_r && in_r.last;

  // Byte stage: header capture and eight division steps
  always_comb begin
    logic [7:0]  fed;
    logic [15:0] d;
    logic [3:0]  pos_inc;
    fed      = in_r.data_byte;
    seq_nxt  = seq_r;
    rcv_nxt  = rcv_r;
    flag_nxt = flag_r;
    priority if (pos_r < fcc_pkg::CHECK_POS_HI) begin
      seq_nxt = {seq_r[23:0], in_r.data_byte};
    end else if (pos_r == fcc_pkg::CHECK_POS_HI) begin
      rcv_nxt = {in_r.data_byte, rcv_r[7:0]};
      fed     = 8'd0;
    end else if (pos_r == fcc_pkg::CHECK_POS_LO) begin
      rcv_nxt = {rcv_r[15:8], in_r.data_byte};
      fed     = 8'd0;
    end else if (pos_r == fcc_pkg::FLAG_POS) begin
      flag_nxt = in_r.data_byte;
    end else begin
      fed = in_r.data_byte;
    end
    d = div_r;
    for (int i = 0; i < 8; i++) begin
      d = fcc_pkg::div_bit(d, generator_r, fed[7-i]);
    end
    div_nxt = d;
    pos_inc = (pos_r < fcc_pkg::HEADER_BYTES) ? (pos_r + 4'd1) : pos_r;
    pos_nxt = pos_inc;

    job.div        = d;
    job.tail       = check_mode_r ? rcv_nxt[14:0] : 15'd0;
    job.short_frag = (pos_inc < fcc_pkg::HEADER_BYTES);
    job.seq        = seq_nxt;
    job.flag       = flag_nxt;
  end

  // Input register and fragment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      pos_r  <= '0;
      div_r  <= '0;
      rcv_r  <= '0;
      seq_r  <= '0;
      flag_r <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (in_v_r && take) begin
        if (in_r.last) begin
          pos_r  <= '0;
          div_r  <= '0;
          rcv_r  <= '0;
          seq_r  <= '0;
          flag_r <= '0;
        end else begin
          pos_r  <= pos_nxt;
          div_r  <= div_nxt;
          rcv_r  <= rcv_nxt;
          seq_r  <= seq_nxt;
          flag_r <= flag_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free) in_r <= in_data;
  end

  // Tail division and result register
  fcc_tail_pipe u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .generator (generator_r),
    .job_valid (job_valid),
    .job       (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/fragment_crc15_checker_tb.sv =====
// ----------------------------------------------------------------------------
// fragment_crc15_checker_tb
// Self-checking bench for the fragment check value block. Fragments of
// random content and length are streamed in under bursty input traffic and
// a stalling receiver. A bit-level model of the header capture and the
// 15-bit long division predicts each result not typed in a directed row,
// and the results are compared field by field in order. The run steps
// through several generator and mode settings.
// ----------------------------------------------------------------------------
module fragment_crc15_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer anywhere
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 88;
  localparam int N_PHASES     = 9;
  localparam int HOLD_CYCLES  = 120;

  // Indexes past the two real registers; writes there are dropped
  localparam logic [fcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [fcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam fcc_pkg::fcc_out_t NO_RES      = '0;
  localparam fcc_pkg::fcc_out_t SHORT_RES   = '{15'd0, 1'b0, 32'd0, 8'd0, 1'b1};
  localparam fcc_pkg::fcc_out_t ZERO_OK_RES = '{15'd0, 1'b1, 32'd0, 8'd0, 1'b0};

  typedef struct packed {
    fcc_pkg::fcc_in_t  beat;
    logic              typed;  // use want instead of the model's answer
    fcc_pkg::fcc_out_t want;
  } byte_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  fcc_pkg::fcc_in_t              in_data;
  logic                          out_valid;
  logic                          out_stall;
  fcc_pkg::fcc_out_t             out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fcc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  // Model of the block's registers and fragment state
  logic              mdl_check_mode;
  logic [15:0]       mdl_generator;
  logic [3:0]        frag_pos;
  logic [15:0]       div_reg;
  logic [15:0]       rx_check;
  logic [31:0]       seq_cap;
  logic [7:0]        flag_cap;
  fcc_pkg::fcc_out_t frag_results_q [$];

  int errors       = 0;
  int results_seen = 0;
  int ok_seen      = 0;
  int short_seen   = 0;
  int bytes_sent   = 0;
  int idle_cycles  = 0;
  int hold_cycles  = 0;
  int burst_left   = 0;
  int gap_pct      = 30;

  // Directed fragments: single byte, one byte short of a header, an all-zero
  // header and an all-ones header
  byte_row_t dir_rows [0:26] = '{
    '{'{8'hFF, 1'b1}, 1'b1, SHORT_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'h80, 1'b1}, 1'b1, SHORT_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b1}, 1'b1, ZERO_OK_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b1}, 1'b0, NO_RES}
  };

  fragment_crc15_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // One division step: shift the bit in, fold in the generator on a carry
  function automatic logic [15:0] crc_shift(input logic [15:0] r, input logic [15:0] g,
                                            input logic b);
    return {r[14:0], b} ^ (r[14] ? g : 16'h0000);
  endfunction

  function automatic void clear_fragment();
    frag_pos = '0;
    div_reg  = '0;
    rx_check = '0;
    seq_cap  = '0;
    flag_cap = '0;
  endfunction

  // Advance the model by one accepted byte; queue a result on the last one
  task automatic track_fragment_byte(input byte_row_t row);
    logic [7:0]        fed;
    logic [14:0]       tail;
    fcc_pkg::fcc_out_t res;
    int                i;
    fed = row.beat.data_byte;
    if (frag_pos < fcc_pkg::CHECK_POS_HI) begin
      seq_cap = {seq_cap[23:0], row.beat.data_byte};
    end else if (frag_pos == fcc_pkg::CHECK_POS_HI) begin
      rx_check[15:8] = row.beat.data_byte;
      fed = '0;
    end else if (frag_pos == fcc_pkg::CHECK_POS_LO) begin
      rx_check[7:0] = row.beat.data_byte;
      fed = '0;
    end else if (frag_pos == fcc_pkg::FLAG_POS) begin
      flag_cap = row.beat.data_byte;
    end
    for (i = 7; i >= 0; i--) div_reg = crc_shift(div_reg, mdl_generator, fed[i]);
    if (frag_pos < fcc_pkg::HEADER_BYTES) frag_pos++;
    if (row.beat.last) begin
      // tail bit 15 of the check field never takes part
      tail = mdl_check_mode ? rx_check[14:0] : 15'd0;
      for (i = 14; i >= 0; i--) div_reg = crc_shift(div_reg, mdl_generator, tail[i]);
      if (frag_pos < fcc_pkg::HEADER_BYTES) res = SHORT_RES;
      else res = '{div_reg[14:0], div_reg == 16'h0000, seq_cap, flag_cap, 1'b0};
      frag_results_q.push_back(row.typed ? row.want : res);
      clear_fragment();
    end
  endtask

  // One input transfer, then maybe a gap before the next burst
  task automatic send_byte(input byte_row_t row);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = row.beat;
    do @(posedge clk); while (in_stall);
    track_fragment_byte(row);
    bytes_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(99) < gap_pct) begin
        repeat ($urandom_range(1, 12)) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Random fragment; optionally with a matching check field, optionally left open
  task automatic send_fragment(input int len, input bit make_good, input bit close);
    logic [7:0]  frag_bytes [$];
    logic [15:0] r;
    logic [7:0]  fed;
    byte_row_t   row;
    int          k;
    int          i;
    for (k = 0; k < len; k++) frag_bytes.push_back(8'($urandom));
    if (make_good && len >= fcc_pkg::HEADER_BYTES) begin
      r = '0;
      for (k = 0; k < len; k++) begin
        fed = (k == fcc_pkg::CHECK_POS_HI || k == fcc_pkg::CHECK_POS_LO) ? 8'h00
                                                                         : frag_bytes[k];
        for (i = 7; i >= 0; i--) r = crc_shift(r, mdl_generator, fed[i]);
      end
      for (i = 0; i < 15; i++) r = crc_shift(r, mdl_generator, 1'b0);
      // top bit of the field stays random
      frag_bytes[fcc_pkg::CHECK_POS_HI] = {frag_bytes[fcc_pkg::CHECK_POS_HI][7], r[14:8]};
      frag_bytes[fcc_pkg::CHECK_POS_LO] = r[7:0];
    end
    for (k = 0; k < len; k++) begin
      row                = '0;
      row.beat.data_byte = frag_bytes[k];
      row.beat.last      = close && (k == len - 1);
      send_byte(row);
    end
  endtask

  // Stop sending, let every queued result arrive, then let the pipe settle
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (frag_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fcc_pkg::CFG_CHECK_MODE: begin
        mdl_check_mode = val[0];
      end
      fcc_pkg::CFG_GENERATOR: begin
        mdl_generator = val;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: stall pattern changes at random intervals; long hold on request
  initial begin : result_sink
    int pattern;
    int span;
    out_stall = 1'b0;
    pattern   = 0;
    span      = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        pattern = $urandom_range(3);
        span    = $urandom_range(20, 200);
      end
      span--;
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else begin
        case (pattern)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(3) == 0);
          2:       out_stall = ($urandom_range(3) != 0);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin : result_check
    fcc_pkg::fcc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.too_short) short_seen++;
      if (out_data.fragment_ok) ok_seen++;
      if (frag_results_q.size() == 0) begin
        errors++;
        $error("result with no fragment outstanding: %p", out_data);
      end else begin
        want = frag_results_q.pop_front();
        if (out_data.remainder !== want.remainder) begin
          errors++;
          $error("remainder: expected %h, got %h", want.remainder, out_data.remainder);
        end
        if (out_data.fragment_ok !== want.fragment_ok) begin
          errors++;
          $error("fragment_ok: expected %b, got %b", want.fragment_ok, out_data.fragment_ok);
        end
        if (out_data.sequence_number !== want.sequence_number) begin
          errors++;
          $error("sequence_number: expected %h, got %h", want.sequence_number,
                 out_data.sequence_number);
        end
        if (out_data.frame_flag !== want.frame_flag) begin
          errors++;
          $error("frame_flag: expected %h, got %h", want.frame_flag, out_data.frame_flag);
        end
        if (out_data.too_short !== want.too_short) begin
          errors++;
          $error("too_short: expected %b, got %b", want.too_short, out_data.too_short);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          p;
    int          n;
    int          len;
    int          pick;
    int          phase_start;
    logic [15:0] gen;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mdl_check_mode = 1'b0;
    mdl_generator  = fcc_pkg::GENERATOR_RESET;
    clear_fragment();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed fragments under reset settings
    foreach (dir_rows[k]) send_byte(dir_rows[k]);
    wait_for_results();

    for (p = 0; p < N_PHASES; p++) begin
      // leave a fragment open across the register writes now and then
      if (p % 3 == 0) begin
        send_fragment($urandom_range(1, 12), 1'b0, 1'b0);
        wait_for_results();
      end

      case (p)
        0, 8:    gen = fcc_pkg::GENERATOR_RESET;
        1, 2:    gen = 16'h8000;
        3, 4:    gen = 16'hFFFF;
        5:       gen = 16'h8000 | 16'($urandom);
        6:       gen = 16'h7FFF & 16'($urandom);
        default: gen = 16'($urandom);
      endcase
      write_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
      write_reg(fcc_pkg::CFG_GENERATOR, gen);
      write_reg(fcc_pkg::CFG_CHECK_MODE, {15'($urandom), p % 3 != 1});
      gap_pct = (p % 4 == 2) ? 0 : 35;

      // receiver holds off while short fragments keep coming, so the block fills
      if (p == 3) begin
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        for (n = 0; n < 40; n++) send_fragment($urandom_range(1, 3), 1'b0, 1'b1);
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 10) len = $urandom_range(1, 8);
        else if (pick < 15) len = $urandom_range(40, 64);
        else len = $urandom_range(9, 24);
        send_fragment(len, $urandom_range(99) < 75, 1'b1);
      end
      wait_for_results();
    end

    $display("%0d bytes sent, %0d results checked (%0d passing, %0d too short)",
             bytes_sent, results_seen, ok_seen, short_seen);
    $display("%0d register settings incl. generator extremes, spare indexes, open fragments",
             N_PHASES + 1);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fcc_pkg.sv
rtl/fcc_tail_pipe.sv
rtl/fragment_crc15_checker.sv
tb/fragment_crc15_checker_tb.sv
